[design/mcfe_pkg.sv]
// shared types and constants for the motor command frame encoder
// no dependencies; imported by every module of the block
`default_nettype none

package mcfe_pkg;

    // frame layout
    localparam int unsigned FRAME_LEN = 17;
    localparam int unsigned CRC_SPAN  = 15;
    localparam int unsigned POS_W     = 5;
    localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(CRC_SPAN);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_LEN - 1);

    // header bytes and crc polynomial (reflected crc-16/kermit)
    localparam logic [7:0]  HDR0     = 8'hFE;
    localparam logic [7:0]  HDR1     = 8'hEE;
    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // input bus width: all command fields packed, no padding
    localparam int unsigned IN_W = 104;

    // one decoded command as it travels through the queue
    typedef struct packed {
        logic [15:0] speed_gain;
        logic [15:0] position_gain;
        logic [31:0] position_cmd;
        logic [15:0] speed_cmd;
        logic [15:0] torque_cmd;
        logic [7:0]  mode;
    } cmd_t;

endpackage

`default_nettype wire

[design/motor_command_frame_encoder.sv]
// top level of the motor command frame encoder
// depends on mcfe_pkg, mcfe_front, mcfe_queue, mcfe_back
//
// usage:
//   s_axis carries one motor command request per transfer; s_axis_tdata
//   holds all seven command fields. m_axis carries the 17-byte frame,
//   one byte per transfer: FE EE, mode, torque, speed, position (low byte
//   first), position gain, speed gain, then the crc-16/kermit over the
//   first 15 bytes, low byte first. m_axis_tlast marks the crc high byte.
//   path: an accepted command passes through the front holding stage,
//   the queue and the back end command register to the output register.
//   throughput: one frame byte per cycle while the receiver takes every
//   byte, frames back to back; the back end serializer, which emits one
//   byte per cycle and folds each payload byte into the crc, sets the rate.
//   a two-entry queue plus a front holding stage absorb up to three
//   commands while a frame is still being sent.
//   reset: all stages empty, no output valid, crc cleared.
//   receiver stall: the output byte holds, the serializer stops, and once
//   the queue and front stage fill, s_axis_tready drops.
`default_nettype none

module motor_command_frame_encoder
    import mcfe_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    // motor_id[3:0], motor_status[7:4], torque_cmd[23:8], speed_cmd[39:24],
    // position_cmd[71:40], position_gain[87:72], speed_gain[103:88]
    input  wire logic [IN_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    // frame_byte[7:0]
    output logic [7:0]           m_axis_tdata,
    output logic                 m_axis_tlast
);

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    // accept and decode
    mcfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // decoupling queue
    mcfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_cmd   (push_cmd),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_cmd   (pop_cmd)
    );

    // frame serializer
    mcfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd_in    (pop_cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

[design/mcfe_front.sv]
// front end: accepts command requests and builds the mode byte
// depends on mcfe_pkg
`default_nettype none

module mcfe_front
    import mcfe_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [IN_W-1:0] in_data,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output cmd_t                 push_cmd
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;

    // decode the packed bus into a command
    always_comb
    begin
        cmd_next.mode          = {in_data[7:4], in_data[3:0]};
        cmd_next.torque_cmd    = in_data[23:8];
        cmd_next.speed_cmd     = in_data[39:24];
        cmd_next.position_cmd  = in_data[71:40];
        cmd_next.position_gain = in_data[87:72];
        cmd_next.speed_gain    = in_data[103:88];
    end

    // one holding stage, refilled in the cycle it drains
    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_cmd   = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

[design/mcfe_queue.sv]
// two-entry command queue between front end and serializer
// depends on mcfe_pkg
`default_nettype none

module mcfe_queue
    import mcfe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  wire cmd_t wr_cmd,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output cmd_t      rd_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

[design/mcfe_back.sv]
// back end: serializes one command into 17 frame bytes with running crc
// depends on mcfe_pkg
`default_nettype none

module mcfe_back
    import mcfe_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cmd_valid,
    output logic       cmd_ready,
    input  wire cmd_t  cmd_in,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [7:0] out_data,
    output logic       out_last
);

    logic             busy_reg;
    logic             busy_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    cmd_t             cmd_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_data_reg;
    logic             out_last_reg;
    logic             out_last_next;
    logic [7:0]       payload [CRC_SPAN];
    logic [7:0]       cur_byte;
    logic             advance;
    logic             load;

    // one crc-16/kermit byte step, lsb first
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // byte order of the crc-covered part of the frame
    always_comb
    begin
        payload[0]  = HDR0;
        payload[1]  = HDR1;
        payload[2]  = cmd_reg.mode;
        payload[3]  = cmd_reg.torque_cmd[15:8];
        payload[4]  = cmd_reg.torque_cmd[7:0];
        payload[5]  = cmd_reg.speed_cmd[15:8];
        payload[6]  = cmd_reg.speed_cmd[7:0];
        payload[7]  = cmd_reg.position_cmd[7:0];
        payload[8]  = cmd_reg.position_cmd[15:8];
        payload[9]  = cmd_reg.position_cmd[23:16];
        payload[10] = cmd_reg.position_cmd[31:24];
        payload[11] = cmd_reg.position_gain[15:8];
        payload[12] = cmd_reg.position_gain[7:0];
        payload[13] = cmd_reg.speed_gain[15:8];
        payload[14] = cmd_reg.speed_gain[7:0];
    end

    // current byte: payload, then crc low and high
    always_comb
    begin
        if (pos_reg == POS_CRC_LO)
        begin
            cur_byte = crc_reg[7:0];
        end
        else if (pos_reg == POS_LAST)
        begin
            cur_byte = crc_reg[15:8];
        end
        else
        begin
            cur_byte = payload[pos_reg[3:0]];
        end
    end

    // handshake: the output register moves when empty or taken
    assign advance   = !out_valid_reg || out_ready;
    assign load      = cmd_valid && (!busy_reg || (advance && pos_reg == POS_LAST));
    assign cmd_ready = load;

    // sequencing, crc and output register next values
    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = busy_reg;
            out_last_next  = busy_reg && (pos_reg == POS_LAST);
            if (busy_reg)
            begin
                if (pos_reg < POS_CRC_LO)
                begin
                    crc_next = crc_step(crc_reg, cur_byte);
                end
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg == POS_LAST)
                begin
                    busy_next = 1'b0;
                end
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            pos_next  = '0;
            crc_next  = CRC_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= cmd_in;
        end
        if (advance && busy_reg)
        begin
            out_data_reg <= cur_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire
